>>> hw/rtl/trsr_pkg.sv
// Shared types and constants for the tach rotor speed regulator.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package trsr_pkg;

    // Field widths fixed by the word formats
    localparam int ROTOR_W   = 3;
    localparam int SECONDS_W = 32;
    localparam int TIMER_W   = 26;
    localparam int RPM_W     = 19;
    localparam int DUTY_W    = 12;
    localparam int LOW_W     = 8;
    localparam int EDGE_W    = 8;
    localparam int STAMP_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // Timestamp arithmetic: stamp = seconds*100000 + (TOP - count)/600
    localparam logic [16:0]        STAMP_SCALE = 17'd100000;
    localparam logic [TIMER_W-1:0] TIMER_TOP   = 26'd59999999;
    // x/600 = (x>>3)/75; (y*RECIP_M)>>30 is exact for y < 2^30/26
    localparam logic [23:0]        RECIP_M     = 24'd14316558;
    localparam int                 RECIP_SH    = 30;
    localparam int                 SUB_Q_W     = 17;
    localparam int                 SUB_PROD_W  = 47;

    localparam logic [RPM_W-1:0]   RPM_MAX     = 19'h7FFFF;
    localparam int                 RPM_PROD_W  = 20;
    localparam logic [LOW_W-1:0]   LOW_SAT     = 8'hFF;

    // Register reset values
    localparam logic [15:0]       TARGET_RST  = 16'd5400;
    localparam logic [15:0]       GLITCH_RST  = 16'd100;
    localparam logic [DUTY_W-1:0] DUTY_MAX_RST = 12'd2300;
    localparam logic [7:0]        FAIL_RST    = 8'd10;
    localparam logic [11:0]       RPE_RST     = 12'd600;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_SPEED = 3'd0,
        CFG_GLITCH_TICKS = 3'd1,
        CFG_DUTY_MAX     = 3'd2,
        CFG_FAIL_LIMIT   = 3'd3,
        CFG_RPM_PER_EDGE = 3'd4
    } cfg_sel_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE_SEC,
        ST_EDGE_SUB,
        ST_EDGE_SUM,
        ST_EDGE_CMP,
        ST_TICK_MUL,
        ST_TICK_UPD
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic edge_sec;
        logic edge_sub;
        logic edge_sum;
        logic edge_cmp;
        logic tick_mul;
        logic tick_upd;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic idx_last;
        logic out_free;
    } status_t;

endpackage

>>> hw/rtl/trsr_ifs.sv
// Valid/ready stream interfaces for tach items and per-rotor results.
// Depends on trsr_pkg for field widths.
`timescale 1ns / 1ps

interface trsr_item_if;
    logic                            valid;
    logic                            ready;
    logic                            func;
    logic [trsr_pkg::ROTOR_W-1:0]    rotor;
    logic [trsr_pkg::SECONDS_W-1:0]  seconds;
    logic [trsr_pkg::TIMER_W-1:0]    timer_count;

    modport source (output valid, func, rotor, seconds, timer_count, input ready);
    modport sink   (input valid, func, rotor, seconds, timer_count, output ready);
endinterface

interface trsr_result_if;
    logic                            valid;
    logic                            ready;
    logic [trsr_pkg::ROTOR_W-1:0]    rotor_index;
    logic [trsr_pkg::RPM_W-1:0]      speed_rpm;
    logic [trsr_pkg::DUTY_W-1:0]     duty;
    logic                            failed;
    logic                            last;

    modport source (output valid, rotor_index, speed_rpm, duty, failed, last,
                    input ready);
    modport sink   (input valid, rotor_index, speed_rpm, duty, failed, last,
                    output ready);
endinterface

>>> hw/rtl/tach_rotor_speed_regulator.sv
// Top level of the tach rotor speed regulator: controller plus datapath.
// Depends on trsr_pkg, trsr_ifs (item/result interfaces), trsr_ctrl, trsr_datapath.
//
//   channel  | dir | word fields
//   ---------+-----+-------------------------------------------------
//   item     | in  | func, rotor, seconds, timer_count
//   result   | out | rotor_index, speed_rpm, duty, failed, last
//   cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// A tach edge word steps through accept, then seconds multiply,
// sub-second reciprocal multiply, stamp add, delta compare and state write.
// A servo tick word is accepted, then walks the rotors: per rotor a multiply step
// for edge_count * rpm_per_edge and an update step into the result
// register. A result stall holds the walk at the update step of the next rotor.
// Reset clears all rotor state and sets the config registers to their defaults at once; no clearing pass.
`timescale 1ns / 1ps

module tach_rotor_speed_regulator #(
    parameter int ROTORS    = 8,
    parameter int EDGE_WRAP = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    trsr_item_if.sink                       item,
    trsr_result_if.source                   result,
    input  logic                            cfg_we,
    input  logic [trsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [trsr_pkg::CFG_W-1:0]      cfg_data
);

    trsr_pkg::cmd_t    cmd;
    trsr_pkg::status_t status;

    // Sequencer
    trsr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_func  (item.func),
        .item_ready (item.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Datapath
    trsr_datapath #(
        .ROTORS    (ROTORS),
        .EDGE_WRAP (EDGE_WRAP)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .item_func        (item.func),
        .item_rotor       (item.rotor),
        .item_seconds     (item.seconds),
        .item_timer_count (item.timer_count),
        .out_valid        (result.valid),
        .out_ready        (result.ready),
        .out_rotor_index  (result.rotor_index),
        .out_speed_rpm    (result.speed_rpm),
        .out_duty         (result.duty),
        .out_failed       (result.failed),
        .out_last         (result.last),
        .cmd              (cmd),
        .status           (status)
    );

endmodule

>>> hw/rtl/trsr_ctrl.sv
// Sequencer for the regulator: steps edge timestamping and the tick walk.
// Depends on trsr_pkg (state_t, cmd_t, status_t).
`timescale 1ns / 1ps

module trsr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_func,
    output logic              item_ready,
    input  trsr_pkg::status_t status,
    output trsr_pkg::cmd_t    cmd
);

    trsr_pkg::state_t state_reg;
    trsr_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= trsr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            trsr_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = item_func ? trsr_pkg::ST_TICK_MUL
                                           : trsr_pkg::ST_EDGE_SEC;
                end
            end
            trsr_pkg::ST_EDGE_SEC: state_next = trsr_pkg::ST_EDGE_SUB;
            trsr_pkg::ST_EDGE_SUB: state_next = trsr_pkg::ST_EDGE_SUM;
            trsr_pkg::ST_EDGE_SUM: state_next = trsr_pkg::ST_EDGE_CMP;
            trsr_pkg::ST_EDGE_CMP: state_next = trsr_pkg::ST_IDLE;
            trsr_pkg::ST_TICK_MUL: state_next = trsr_pkg::ST_TICK_UPD;
            trsr_pkg::ST_TICK_UPD:
            begin
                if (status.out_free)
                begin
                    state_next = status.idx_last ? trsr_pkg::ST_IDLE
                                                 : trsr_pkg::ST_TICK_MUL;
                end
            end
            default: state_next = trsr_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        item_ready = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            trsr_pkg::ST_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.capture = item_valid;
            end
            trsr_pkg::ST_EDGE_SEC: cmd.edge_sec = 1'b1;
            trsr_pkg::ST_EDGE_SUB: cmd.edge_sub = 1'b1;
            trsr_pkg::ST_EDGE_SUM: cmd.edge_sum = 1'b1;
            trsr_pkg::ST_EDGE_CMP: cmd.edge_cmp = 1'b1;
            trsr_pkg::ST_TICK_MUL: cmd.tick_mul = 1'b1;
            trsr_pkg::ST_TICK_UPD: cmd.tick_upd = status.out_free;
            default:
            begin
                item_ready = 1'b0;
                cmd        = '0;
            end
        endcase
    end

endmodule

>>> hw/rtl/trsr_datapath.sv
// Datapath: config registers, per-rotor state, timestamp and servo math,
// result word register. Depends on trsr_pkg; driven by trsr_ctrl commands.
`timescale 1ns / 1ps

module trsr_datapath #(
    parameter int ROTORS    = 8,
    parameter int EDGE_WRAP = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [trsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [trsr_pkg::CFG_W-1:0]      cfg_data,
    // input word payload
    input  logic                            item_func,
    input  logic [trsr_pkg::ROTOR_W-1:0]    item_rotor,
    input  logic [trsr_pkg::SECONDS_W-1:0]  item_seconds,
    input  logic [trsr_pkg::TIMER_W-1:0]    item_timer_count,
    // result word
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [trsr_pkg::ROTOR_W-1:0]    out_rotor_index,
    output logic [trsr_pkg::RPM_W-1:0]      out_speed_rpm,
    output logic [trsr_pkg::DUTY_W-1:0]     out_duty,
    output logic                            out_failed,
    output logic                            out_last,
    // sequencer link
    input  trsr_pkg::cmd_t                  cmd,
    output trsr_pkg::status_t               status
);

    localparam int IDX_W = (ROTORS > 1) ? $clog2(ROTORS) : 1;

    // Configuration registers
    logic [15:0]                  target_reg;
    logic [15:0]                  glitch_reg;
    logic [trsr_pkg::DUTY_W-1:0]  duty_max_reg;
    logic [7:0]                   fail_limit_reg;
    logic [11:0]                  rpe_reg;

    // Per-rotor state
    logic [trsr_pkg::STAMP_W-1:0] prev_stamp_reg [ROTORS];
    logic [trsr_pkg::EDGE_W-1:0]  edge_count_reg [ROTORS];
    logic [trsr_pkg::DUTY_W-1:0]  duty_val_reg   [ROTORS];
    logic [trsr_pkg::LOW_W-1:0]   low_ticks_reg  [ROTORS];
    logic                         fail_flag_reg  [ROTORS];

    // Working registers
    logic [IDX_W-1:0]                 idx_reg;
    logic [IDX_W-1:0]                 idx_next;
    logic                             rotor_ok_reg;
    logic [trsr_pkg::TIMER_W-1:0]     x_reg;
    logic [trsr_pkg::TIMER_W-1:0]     x_next;
    logic [trsr_pkg::SECONDS_W-1:0]   sec_reg;
    logic [trsr_pkg::STAMP_W-1:0]     sec_prod_reg;
    logic [trsr_pkg::SUB_Q_W-1:0]     sub_q_reg;
    logic [trsr_pkg::STAMP_W-1:0]     stamp_reg;
    logic [trsr_pkg::RPM_PROD_W-1:0]  rpm_prod_reg;
    logic                             out_valid_reg;
    logic [trsr_pkg::ROTOR_W-1:0]     out_rotor_reg;
    logic [trsr_pkg::RPM_W-1:0]       out_rpm_reg;
    logic [trsr_pkg::DUTY_W-1:0]      out_duty_reg;
    logic                             out_failed_reg;
    logic                             out_last_reg;

    // Combinational values
    logic [trsr_pkg::SUB_PROD_W-1:0]  sub_prod;
    logic [trsr_pkg::STAMP_W-1:0]     delta;
    logic                             edge_take;
    logic [trsr_pkg::EDGE_W:0]        edge_inc;
    logic [trsr_pkg::EDGE_W-1:0]      edge_next;
    logic [trsr_pkg::RPM_W-1:0]       rpm;
    logic [trsr_pkg::DUTY_W-1:0]      duty_cur;
    logic [trsr_pkg::DUTY_W-1:0]      duty_next;
    logic [trsr_pkg::LOW_W-1:0]       low_cur;
    logic [trsr_pkg::LOW_W-1:0]       low_next;
    logic                             fail_next;
    logic                             idx_last;
    logic                             out_free;

    assign idx_last = (idx_reg == IDX_W'(ROTORS - 1));
    assign out_free = !out_valid_reg || out_ready;
    assign status   = '{idx_last: idx_last, out_free: out_free};

    // Configuration decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= trsr_pkg::TARGET_RST;
            glitch_reg     <= trsr_pkg::GLITCH_RST;
            duty_max_reg   <= trsr_pkg::DUTY_MAX_RST;
            fail_limit_reg <= trsr_pkg::FAIL_RST;
            rpe_reg        <= trsr_pkg::RPE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                trsr_pkg::CFG_TARGET_SPEED: target_reg     <= cfg_data;
                trsr_pkg::CFG_GLITCH_TICKS: glitch_reg     <= cfg_data;
                trsr_pkg::CFG_DUTY_MAX:     duty_max_reg   <= cfg_data[11:0];
                trsr_pkg::CFG_FAIL_LIMIT:   fail_limit_reg <= cfg_data[7:0];
                trsr_pkg::CFG_RPM_PER_EDGE: rpe_reg        <= cfg_data[11:0];
                default:                    ;
            endcase
        end
    end

    // Sub-second part: counts elapsed since the top; out-of-range counts give zero
    always_comb
    begin
        if (item_timer_count > trsr_pkg::TIMER_TOP)
        begin
            x_next = '0;
        end
        else
        begin
            x_next = trsr_pkg::TIMER_TOP - item_timer_count;
        end
    end

    // Divide by 600 through a reciprocal of 75 on x/8
    assign sub_prod = trsr_pkg::SUB_PROD_W'(x_reg[trsr_pkg::TIMER_W-1:3])
                    * trsr_pkg::SUB_PROD_W'(trsr_pkg::RECIP_M);

    // Edge filter and count step
    assign delta     = stamp_reg - prev_stamp_reg[idx_reg];
    assign edge_take = rotor_ok_reg && (delta > 32'(glitch_reg));
    assign edge_inc  = {1'b0, edge_count_reg[idx_reg]} + 9'd1;
    assign edge_next = (edge_inc >= 9'(EDGE_WRAP)) ? '0 : edge_inc[7:0];

    // Servo update for the rotor at idx
    always_comb
    begin
        if (rpm_prod_reg > 20'(trsr_pkg::RPM_MAX))
        begin
            rpm = trsr_pkg::RPM_MAX;
        end
        else
        begin
            rpm = rpm_prod_reg[trsr_pkg::RPM_W-1:0];
        end

        duty_cur = duty_val_reg[idx_reg];
        low_cur  = low_ticks_reg[idx_reg];

        if (rpm < 19'(target_reg))
        begin
            duty_next = (duty_cur < duty_max_reg) ? duty_cur + 12'd1 : duty_cur;
        end
        else
        begin
            duty_next = (duty_cur != '0) ? duty_cur - 12'd1 : duty_cur;
        end

        if (rpm < 19'(target_reg >> 1))
        begin
            low_next  = (low_cur != trsr_pkg::LOW_SAT) ? low_cur + 8'd1 : low_cur;
            fail_next = fail_flag_reg[idx_reg] || (low_next > fail_limit_reg);
        end
        else
        begin
            low_next  = '0;
            fail_next = 1'b0;
        end
    end

    // Rotor index: set on capture, stepped after each servo update
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.capture)
        begin
            idx_next = item_func ? '0 : IDX_W'(item_rotor);
        end
        else if (cmd.tick_upd)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    // Working registers (payload, no reset)
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.capture)
        begin
            rotor_ok_reg <= (int'(item_rotor) < ROTORS);
            x_reg        <= x_next;
            sec_reg      <= item_seconds;
        end
        if (cmd.edge_sec)
        begin
            sec_prod_reg <= 32'(sec_reg * 32'(trsr_pkg::STAMP_SCALE));
        end
        if (cmd.edge_sub)
        begin
            sub_q_reg <= sub_prod[trsr_pkg::SUB_PROD_W-1:trsr_pkg::RECIP_SH];
        end
        if (cmd.edge_sum)
        begin
            stamp_reg <= sec_prod_reg + 32'(sub_q_reg);
        end
        if (cmd.tick_mul)
        begin
            rpm_prod_reg <= trsr_pkg::RPM_PROD_W'(edge_count_reg[idx_reg])
                          * trsr_pkg::RPM_PROD_W'(rpe_reg);
        end
        if (cmd.tick_upd)
        begin
            out_rotor_reg  <= trsr_pkg::ROTOR_W'(idx_reg);
            out_rpm_reg    <= rpm;
            out_duty_reg   <= duty_next;
            out_failed_reg <= fail_next;
            out_last_reg   <= idx_last;
        end
    end

    // Per-rotor state, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROTORS; i++)
            begin
                prev_stamp_reg[i] <= '0;
                edge_count_reg[i] <= '0;
                duty_val_reg[i]   <= '0;
                low_ticks_reg[i]  <= '0;
                fail_flag_reg[i]  <= 1'b0;
            end
        end
        else if (cmd.edge_cmp && edge_take)
        begin
            prev_stamp_reg[idx_reg] <= stamp_reg;
            edge_count_reg[idx_reg] <= edge_next;
        end
        else if (cmd.tick_upd)
        begin
            edge_count_reg[idx_reg] <= '0;
            duty_val_reg[idx_reg]   <= duty_next;
            low_ticks_reg[idx_reg]  <= low_next;
            fail_flag_reg[idx_reg]  <= fail_next;
        end
    end

    // Result word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.tick_upd)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_rotor_index = out_rotor_reg;
    assign out_speed_rpm   = out_rpm_reg;
    assign out_duty        = out_duty_reg;
    assign out_failed      = out_failed_reg;
    assign out_last        = out_last_reg;

endmodule

>>> hw/rtl/trsr_checker.sv
// Port-level assertions for the regulator, bound to the top level.
// Depends on trsr_pkg for field widths; attached by the bind below.
`timescale 1ns / 1ps

module trsr_checker #(
    parameter int ROTORS = 8
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [trsr_pkg::ROTOR_W-1:0]  res_rotor_index,
    input logic [trsr_pkg::RPM_W-1:0]    res_speed_rpm,
    input logic [trsr_pkg::DUTY_W-1:0]   res_duty,
    input logic                          res_failed,
    input logic                          res_last
);

    // Stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_rotor_index)
            && $stable(res_speed_rpm) && $stable(res_duty)
            && $stable(res_failed) && $stable(res_last))
        else $error("result word changed while stalled");

    // The final word of a tick describes the highest rotor
    a_last_rotor: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_last |-> res_rotor_index == trsr_pkg::ROTOR_W'(ROTORS - 1))
        else $error("last flag on wrong rotor");

    // Every accepted word leaves the block busy in the cycle after the accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("ready right after accept");

    // No new word while a tick walk is still producing results
    a_walk_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_last |-> !item_ready)
        else $error("input ready during tick walk");

endmodule

bind tach_rotor_speed_regulator trsr_checker #(
    .ROTORS (ROTORS)
) u_trsr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .res_rotor_index (result.rotor_index),
    .res_speed_rpm   (result.speed_rpm),
    .res_duty        (result.duty),
    .res_failed      (result.failed),
    .res_last        (result.last)
);
